// ===== src/srm_pkg.sv =====
// Shared types and codes for the serial response matcher.
`default_nettype none

package srm_pkg;

  localparam int unsigned CFG_W   = 64;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned TMO_W   = 16;
  localparam int unsigned TICK_W  = 17;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_BYTE  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_WAITING   = 3'd1;
  localparam logic [2:0] ST_PRIMARY   = 3'd2;
  localparam logic [2:0] ST_SECONDARY = 3'd3;
  localparam logic [2:0] ST_CMD_ERROR = 3'd4;
  localparam logic [2:0] ST_TIMEOUT   = 3'd5;

  localparam logic [IDX_W-1:0] REG_PRIMARY_PATTERN   = 3'd0;
  localparam logic [IDX_W-1:0] REG_PRIMARY_LENGTH    = 3'd1;
  localparam logic [IDX_W-1:0] REG_SECONDARY_PATTERN = 3'd2;
  localparam logic [IDX_W-1:0] REG_SECONDARY_LENGTH  = 3'd3;
  localparam logic [IDX_W-1:0] REG_TIMEOUT_TICKS     = 3'd4;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] error_byte;
  } out_item_t;

  typedef struct packed {
    logic             hit;
    logic             done;
    logic [POS_W-1:0] pos_next;
  } track_t;

endpackage

`default_nettype wire

// ===== src/srm_track.sv =====
// Position tracker for one expected byte pattern.
`default_nettype none

module srm_track #(
  parameter int unsigned PATTERN_BYTES = 8
) (
  input  wire logic [PATTERN_BYTES*8-1:0]   pattern,
  input  wire logic [srm_pkg::LEN_W-1:0]    length,
  input  wire logic [srm_pkg::POS_W-1:0]    pos,
  input  wire logic [7:0]                   rx_byte,
  output srm_pkg::track_t                   track
);

  logic [7:0]                sel_byte;
  logic                      in_range;
  logic [srm_pkg::POS_W-1:0] pos_inc;

  always_comb begin
    sel_byte = 8'd0;
    in_range = 1'b0;
    for (int i = 0; i < int'(PATTERN_BYTES); i++) begin
      if (pos == srm_pkg::POS_W'(i)) begin
        sel_byte = pattern[8*i +: 8];
        in_range = 1'b1;
      end
    end
  end

  assign pos_inc        = pos + srm_pkg::POS_W'(1);
  assign track.hit      = (length != '0) && in_range && (sel_byte == rx_byte);
  assign track.done     = track.hit && (pos_inc >= srm_pkg::POS_W'(length));
  assign track.pos_next = track.hit ? pos_inc : '0;

endmodule

`default_nettype wire

// ===== src/serial_response_matcher_core.sv =====
// Top level of the serial response matcher with tick timeout.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | in_data   (op, rx_byte)
//  out     | output    | out_valid / out_stall| out_data  (status, error_byte)
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// One item per cycle while in_stall is low; each result is registered.
// The match positions and tick count update in the cycle of the transfer.
// A two-entry output buffer (output register plus skid) keeps input open for
// one item while the output is stalled; in_stall rises only when both are full.
// Synchronous reset clears the wait state and buffers and sets config defaults.
`default_nettype none

module serial_response_matcher_core #(
  parameter int unsigned PATTERN_BYTES = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire srm_pkg::in_item_t             in_data,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      srm_pkg::out_item_t            out_data,
  input  wire logic                          cfg_we,
  input  wire logic [srm_pkg::IDX_W-1:0]     cfg_index,
  input  wire logic [srm_pkg::CFG_W-1:0]     cfg_data
);

  localparam int unsigned PAT_W = PATTERN_BYTES * 8;

  logic [PAT_W-1:0]           primary_pattern;
  logic [srm_pkg::LEN_W-1:0]  primary_length;
  logic [PAT_W-1:0]           secondary_pattern;
  logic [srm_pkg::LEN_W-1:0]  secondary_length;
  logic [srm_pkg::TMO_W-1:0]  timeout_ticks;

  logic                       waiting;
  logic [srm_pkg::POS_W-1:0]  primary_position;
  logic [srm_pkg::POS_W-1:0]  secondary_position;
  logic [srm_pkg::TICK_W-1:0] elapsed_ticks;

  logic                       waiting_next;
  logic [srm_pkg::POS_W-1:0]  primary_position_next;
  logic [srm_pkg::POS_W-1:0]  secondary_position_next;
  logic [srm_pkg::TICK_W-1:0] elapsed_ticks_next;
  srm_pkg::out_item_t         result;

  logic                       skid_valid;
  srm_pkg::out_item_t         skid_data;

  logic [srm_pkg::LEN_W-1:0]  plen;
  logic [srm_pkg::LEN_W-1:0]  slen;
  srm_pkg::track_t            p_trk;
  srm_pkg::track_t            s_trk;
  logic                       take;

  assign plen = (primary_length > srm_pkg::LEN_W'(PATTERN_BYTES)) ?
                srm_pkg::LEN_W'(PATTERN_BYTES) : primary_length;
  assign slen = (secondary_length > srm_pkg::LEN_W'(PATTERN_BYTES)) ?
                srm_pkg::LEN_W'(PATTERN_BYTES) : secondary_length;

  srm_track #(.PATTERN_BYTES(PATTERN_BYTES)) u_primary (
    .pattern (primary_pattern),
    .length  (plen),
    .pos     (primary_position),
    .rx_byte (in_data.rx_byte),
    .track   (p_trk)
  );

  srm_track #(.PATTERN_BYTES(PATTERN_BYTES)) u_secondary (
    .pattern (secondary_pattern),
    .length  (slen),
    .pos     (secondary_position),
    .rx_byte (in_data.rx_byte),
    .track   (s_trk)
  );

  assign in_stall = skid_valid;
  assign take     = in_valid && !skid_valid;

  always_comb begin
    waiting_next            = waiting;
    primary_position_next   = primary_position;
    secondary_position_next = secondary_position;
    elapsed_ticks_next      = elapsed_ticks;
    result.status           = srm_pkg::ST_WAITING;
    result.error_byte       = 8'd0;
    if (in_data.op == srm_pkg::OP_START) begin
      waiting_next            = 1'b1;
      primary_position_next   = '0;
      secondary_position_next = '0;
      elapsed_ticks_next      = '0;
    end else if (!waiting || in_data.op == srm_pkg::OP_RSVD) begin
      result.status = waiting ? srm_pkg::ST_WAITING : srm_pkg::ST_IDLE;
    end else begin
      if (in_data.op == srm_pkg::OP_BYTE) begin
        primary_position_next = p_trk.pos_next;
        if (p_trk.done) begin
          result.status = srm_pkg::ST_PRIMARY;
        end else if (!p_trk.hit && plen == srm_pkg::LEN_W'(2) &&
                     primary_position == srm_pkg::POS_W'(1)) begin
          result.status     = srm_pkg::ST_CMD_ERROR;
          result.error_byte = in_data.rx_byte;
        end
        if (result.status == srm_pkg::ST_WAITING) begin
          secondary_position_next = s_trk.pos_next;
          if (s_trk.done) begin
            result.status = srm_pkg::ST_SECONDARY;
          end
        end
      end else if (elapsed_ticks != '1) begin
        elapsed_ticks_next = elapsed_ticks + srm_pkg::TICK_W'(1);
      end
      if (result.status == srm_pkg::ST_WAITING &&
          elapsed_ticks_next > srm_pkg::TICK_W'(timeout_ticks)) begin
        result.status = srm_pkg::ST_TIMEOUT;
      end
      waiting_next = (result.status == srm_pkg::ST_WAITING);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      primary_pattern    <= '0;
      primary_length     <= srm_pkg::LEN_W'(2);
      secondary_pattern  <= '0;
      secondary_length   <= '0;
      timeout_ticks      <= srm_pkg::TMO_W'(60);
    end else if (cfg_we) begin
      unique case (cfg_index)
        srm_pkg::REG_PRIMARY_PATTERN:   primary_pattern   <= cfg_data[PAT_W-1:0];
        srm_pkg::REG_PRIMARY_LENGTH:    primary_length    <= cfg_data[srm_pkg::LEN_W-1:0];
        srm_pkg::REG_SECONDARY_PATTERN: secondary_pattern <= cfg_data[PAT_W-1:0];
        srm_pkg::REG_SECONDARY_LENGTH:  secondary_length  <= cfg_data[srm_pkg::LEN_W-1:0];
        srm_pkg::REG_TIMEOUT_TICKS:     timeout_ticks     <= cfg_data[srm_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      waiting            <= 1'b0;
      primary_position   <= '0;
      secondary_position <= '0;
      elapsed_ticks      <= '0;
    end else if (take) begin
      waiting            <= waiting_next;
      primary_position   <= primary_position_next;
      secondary_position <= secondary_position_next;
      elapsed_ticks      <= elapsed_ticks_next;
    end
  end

  // advance the output register from the skid first, else from the new transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else if (take) begin
        out_data  <= result;
        out_valid <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (take) begin
      skid_data  <= result;
      skid_valid <= 1'b1;
    end
  end

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_start_arms: assert property (@(posedge clk) disable iff (rst)
    (take && in_data.op == srm_pkg::OP_START) |=> waiting)
    else $error("start transfer did not arm the wait");

  a_error_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != srm_pkg::ST_CMD_ERROR) |-> (out_data.error_byte == 8'd0))
    else $error("error byte set without command error");

  a_done_ends_wait: assert property (@(posedge clk) disable iff (rst)
    (take && in_data.op != srm_pkg::OP_START && result.status != srm_pkg::ST_WAITING)
    |=> !waiting)
    else $error("wait still armed after final status");
`endif

endmodule

`default_nettype wire

// ===== test/serial_response_matcher_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench: random and directed start, byte and tick traffic against a model.
module serial_response_matcher_core_tb;

  localparam int unsigned PATTERN_BYTES = 8;
  localparam int unsigned PHASE_ITEMS   = 96;
  localparam int unsigned HOLD_CYCLES   = 40;
  localparam int unsigned RUN_LIMIT_NS  = 2_000_000;
  localparam logic [srm_pkg::IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          in_valid  = 1'b0;
  logic                          in_stall;
  srm_pkg::in_item_t             in_data   = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  srm_pkg::out_item_t            out_data;
  logic                          cfg_we    = 1'b0;
  logic [srm_pkg::IDX_W-1:0]     cfg_index = '0;
  logic [srm_pkg::CFG_W-1:0]     cfg_data  = '0;

  serial_response_matcher_core #(.PATTERN_BYTES(PATTERN_BYTES)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register copies and matcher state
  logic [srm_pkg::CFG_W-1:0]  prim_pat   = '0;
  logic [srm_pkg::LEN_W-1:0]  prim_len   = 4'd2;
  logic [srm_pkg::CFG_W-1:0]  alt_pat    = '0;
  logic [srm_pkg::LEN_W-1:0]  alt_len    = 4'd0;
  logic [srm_pkg::TMO_W-1:0]  tick_limit = 16'd60;
  logic                       wait_armed = 1'b0;
  logic [srm_pkg::POS_W-1:0]  prim_pos   = '0;
  logic [srm_pkg::POS_W-1:0]  alt_pos    = '0;
  logic [srm_pkg::TICK_W-1:0] tick_count = '0;

  srm_pkg::in_item_t    pending_items[$];
  srm_pkg::out_item_t   expected_responses[$];
  int unsigned queued_items    = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned recv_idle_pct   = 0;
  int unsigned transfers_in    = 0;
  int unsigned stalled_offers  = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned status_count [0:7];
  int unsigned hold_reqs   = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left   = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [srm_pkg::LEN_W-1:0] clamp_len(logic [srm_pkg::LEN_W-1:0] len);
    return (len > PATTERN_BYTES) ? srm_pkg::LEN_W'(PATTERN_BYTES) : len;
  endfunction

  function automatic logic pattern_hit(logic [srm_pkg::CFG_W-1:0] pat,
                                       logic [srm_pkg::POS_W-1:0] pos,
                                       logic [7:0] b);
    if (pos >= PATTERN_BYTES) return 1'b0;
    return pat[8*pos +: 8] == b;
  endfunction

  function automatic srm_pkg::out_item_t predict_response(srm_pkg::in_item_t it);
    srm_pkg::out_item_t r;
    logic [srm_pkg::LEN_W-1:0] plen;
    logic [srm_pkg::LEN_W-1:0] alen;
    plen = clamp_len(prim_len);
    alen = clamp_len(alt_len);
    r.status     = srm_pkg::ST_IDLE;
    r.error_byte = 8'h00;
    if (it.op == srm_pkg::OP_START) begin
      wait_armed = 1'b1;
      prim_pos   = '0;
      alt_pos    = '0;
      tick_count = '0;
      r.status   = srm_pkg::ST_WAITING;
    end else if (!wait_armed || it.op == srm_pkg::OP_RSVD) begin
      r.status = wait_armed ? srm_pkg::ST_WAITING : srm_pkg::ST_IDLE;
    end else begin
      r.status = srm_pkg::ST_WAITING;
      if (it.op == srm_pkg::OP_BYTE) begin
        if (plen != 0 && pattern_hit(prim_pat, prim_pos, it.rx_byte)) begin
          prim_pos = prim_pos + 1'b1;
          if (prim_pos >= plen) r.status = srm_pkg::ST_PRIMARY;
        end else begin
          if (plen == 2 && prim_pos == 1) begin
            r.status     = srm_pkg::ST_CMD_ERROR;
            r.error_byte = it.rx_byte;
          end
          prim_pos = '0;
        end
        if (r.status == srm_pkg::ST_WAITING) begin
          if (alen != 0 && pattern_hit(alt_pat, alt_pos, it.rx_byte)) begin
            alt_pos = alt_pos + 1'b1;
            if (alt_pos >= alen) r.status = srm_pkg::ST_SECONDARY;
          end else begin
            alt_pos = '0;
          end
        end
      end else if (tick_count != {srm_pkg::TICK_W{1'b1}}) begin
        tick_count = tick_count + 1'b1;
      end
      if (r.status == srm_pkg::ST_WAITING && tick_count > tick_limit)
        r.status = srm_pkg::ST_TIMEOUT;
      if (r.status != srm_pkg::ST_WAITING) wait_armed = 1'b0;
    end
    return r;
  endfunction

  // driver: present queued items, predict on each transfer
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_stall) stalled_offers++;
      if (in_valid && !in_stall) begin
        expected_responses.push_back(predict_response(in_data));
        transfers_in++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_reqs != hold_served) begin
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_reqs;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic report_mismatch(string why, srm_pkg::out_item_t want,
                                 srm_pkg::out_item_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: status exp %0d got %0d, error_byte exp %02h got %02h",
               $realtime, why, want.status, got.status, want.error_byte, got.error_byte);
  endtask

  // monitor: check each result transfer against the oldest prediction
  always @(posedge clk) begin : monitor
    srm_pkg::out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_responses.size() == 0) begin
          report_mismatch("result with nothing pending", '0, out_data);
        end else begin
          want = expected_responses.pop_front();
          results_checked++;
          if (out_data.status !== want.status || out_data.error_byte !== want.error_byte)
            report_mismatch("wrong result", want, out_data);
          status_count[want.status]++;
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic push_item(logic [1:0] op, logic [7:0] b);
    srm_pkg::in_item_t it;
    it.op      = op;
    it.rx_byte = b;
    pending_items.push_back(it);
    queued_items++;
  endtask

  task automatic put_reg(logic [srm_pkg::IDX_W-1:0] idx, logic [srm_pkg::CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic configure(logic [srm_pkg::CFG_W-1:0] pp, logic [srm_pkg::LEN_W-1:0] pl,
                           logic [srm_pkg::CFG_W-1:0] sp, logic [srm_pkg::LEN_W-1:0] sl,
                           logic [srm_pkg::TMO_W-1:0] tmo);
    put_reg(srm_pkg::REG_PRIMARY_PATTERN, pp);
    put_reg(srm_pkg::REG_PRIMARY_LENGTH, {32'($urandom), 28'($urandom), pl});
    put_reg(srm_pkg::REG_SECONDARY_PATTERN, sp);
    put_reg(srm_pkg::REG_SECONDARY_LENGTH, {32'($urandom), 28'($urandom), sl});
    put_reg(srm_pkg::REG_TIMEOUT_TICKS, {32'($urandom), 16'($urandom), tmo});
    put_reg(REG_UNUSED, {32'($urandom), 32'($urandom)});
    cfg_we     <= 1'b0;
    prim_pat   = pp;
    prim_len   = pl;
    alt_pat    = sp;
    alt_len    = sl;
    tick_limit = tmo;
  endtask

  function automatic logic [srm_pkg::CFG_W-1:0] rand_pattern(logic narrow);
    logic [srm_pkg::CFG_W-1:0] p;
    for (int i = 0; i < PATTERN_BYTES; i++)
      p[8*i +: 8] = narrow ? ($urandom_range(1) ? 8'h41 : 8'h42) : 8'($urandom);
    return p;
  endfunction

  // mostly well-formed exchanges with random content, some noise and broken ones
  task automatic queue_exchanges(int unsigned n);
    int unsigned target;
    int unsigned kind;
    int unsigned len;
    int unsigned cut;
    int unsigned stray;
    logic [srm_pkg::CFG_W-1:0] pat;
    target = queued_items + n;
    while (queued_items < target) begin
      kind = $urandom_range(19);
      if (kind < 2) begin
        push_item(2'($urandom_range(3)), 8'($urandom));
      end else begin
        if (kind != 2) push_item(srm_pkg::OP_START, 8'($urandom));
        if (kind < 12 && clamp_len(prim_len) != 0) begin
          pat = prim_pat;
          len = clamp_len(prim_len);
        end else if (clamp_len(alt_len) != 0) begin
          pat = alt_pat;
          len = clamp_len(alt_len);
        end else begin
          pat = prim_pat;
          len = (clamp_len(prim_len) != 0) ? clamp_len(prim_len) : 3;
        end
        cut = (kind >= 16 && kind < 18) ? $urandom_range(len) : len;
        for (int unsigned i = 0; i < cut; i++) begin
          if ($urandom_range(5) == 0) push_item(srm_pkg::OP_TICK, 8'($urandom));
          if ($urandom_range(9) == 0) begin
            stray = $urandom_range(len - 1);
            push_item(srm_pkg::OP_BYTE, pat[8*stray +: 8]);
          end
          push_item(srm_pkg::OP_BYTE, pat[8*i +: 8]);
        end
        if (cut < len) push_item(srm_pkg::OP_BYTE, 8'($urandom));
        if (kind >= 18)
          repeat ($urandom_range(24, 1)) push_item(srm_pkg::OP_TICK, 8'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_items.size() != 0 || in_valid || expected_responses.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(logic [srm_pkg::CFG_W-1:0] pp, logic [srm_pkg::LEN_W-1:0] pl,
                           logic [srm_pkg::CFG_W-1:0] sp, logic [srm_pkg::LEN_W-1:0] sl,
                           logic [srm_pkg::TMO_W-1:0] tmo,
                           int unsigned send_pct, int unsigned recv_pct, logic pressure);
    configure(pp, pl, sp, sl, tmo);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    queue_exchanges(PHASE_ITEMS);
    // leave a wait part way through so the next setting lands mid-wait
    push_item(srm_pkg::OP_START, 8'($urandom));
    for (int unsigned i = 0; i + 1 < clamp_len(prim_len); i++)
      push_item(srm_pkg::OP_BYTE, prim_pat[8*i +: 8]);
    if (pressure) hold_reqs <= hold_reqs + 1;
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < 8; i++) status_count[i] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    configure(64'h4B4F, 4'd2, 64'h52_5245, 4'd3, 16'd2);
    send_idle_pct = 23;
    recv_idle_pct = 71;
    push_item(srm_pkg::OP_BYTE, 8'hFF);
    push_item(srm_pkg::OP_TICK, 8'h00);
    push_item(srm_pkg::OP_RSVD, 8'hAA);
    push_item(srm_pkg::OP_START, 8'h55);
    push_item(srm_pkg::OP_RSVD, 8'h00);
    push_item(srm_pkg::OP_BYTE, 8'h4F);
    push_item(srm_pkg::OP_BYTE, 8'h4B);
    push_item(srm_pkg::OP_START, 8'h00);
    push_item(srm_pkg::OP_BYTE, 8'h4F);
    push_item(srm_pkg::OP_BYTE, 8'h00);
    push_item(srm_pkg::OP_START, 8'hFF);
    push_item(srm_pkg::OP_BYTE, 8'h45);
    push_item(srm_pkg::OP_BYTE, 8'h52);
    push_item(srm_pkg::OP_BYTE, 8'h52);
    push_item(srm_pkg::OP_START, 8'h00);
    push_item(srm_pkg::OP_BYTE, 8'hFF);
    push_item(srm_pkg::OP_START, 8'h00);
    push_item(srm_pkg::OP_TICK, 8'hFF);
    push_item(srm_pkg::OP_TICK, 8'h00);
    push_item(srm_pkg::OP_TICK, 8'h00);
    wait_drained();

    run_phase(rand_pattern(1'b1), 4'd3, rand_pattern(1'b1), 4'd4, 16'd12, 23, 71, 1'b0);
    run_phase({srm_pkg::CFG_W{1'b1}}, 4'd8, '0, 4'd15, 16'd0, 23, 71, 1'b0);
    run_phase(rand_pattern(1'b0), 4'd0, rand_pattern(1'b1), 4'd2, 16'hFFFF, 71, 23, 1'b0);
    run_phase(rand_pattern(1'b1), 4'd2, rand_pattern(1'b0), 4'd9, 16'd20, 71, 23, 1'b0);
    run_phase(rand_pattern(1'b1), 4'd15, rand_pattern(1'b1), 4'd1, 16'd30, 0, 0, 1'b1);
    run_phase(rand_pattern(1'b0), 4'd1, rand_pattern(1'b1), 4'd8, 16'd3, 0, 0, 1'b0);

    $display("Checked %0d results from %0d transfers over seven register settings,",
             results_checked, transfers_in);
    $display("%0d primary, %0d secondary, %0d command error, %0d timeout; %0d stalled offers",
             status_count[srm_pkg::ST_PRIMARY], status_count[srm_pkg::ST_SECONDARY],
             status_count[srm_pkg::ST_CMD_ERROR], status_count[srm_pkg::ST_TIMEOUT],
             stalled_offers);
    if (mismatches == 0 && expected_responses.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
